// ----- rtl/dda_pkg.sv -----
package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
    // Increment magnitude is at most one pixel, so it needs one integer bit.
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int STEP_BITS  = QUO_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(ACC_BITS);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quo;
    } div_rsp_t;

endpackage

// ----- rtl/dda_div.sv -----
module dda_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dda_pkg::div_req_t req,
    output dda_pkg::div_rsp_t rsp
);
    import dda_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(ACC_BITS - 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] den_reg, den_next;
    logic [ACC_BITS-1:0]   dvd_reg, dvd_next;
    logic [ACC_BITS-1:0]   quo_reg, quo_next;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;
    logic                  rnd;

    // One restoring step per cycle: shift in the next dividend bit and try a subtract.
    assign trial = {rem_reg, dvd_reg[ACC_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // Round to nearest with ties away from zero: bump when twice the remainder
    // reaches the divisor.
    assign rnd   = {rem_reg, 1'b0} >= {1'b0, den_reg};

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg[QUO_BITS-1:0] + QUO_BITS'(rnd);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_LAST;
            rem_next = '0;
            den_next = req.den;
            dvd_next = {req.num, {FRAC_BITS{1'b0}}};
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            dvd_next = {dvd_reg[ACC_BITS-2:0], 1'b0};
            quo_next = {quo_reg[ACC_BITS-2:0], ge};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- rtl/dda_line_rasterizer_top.sv -----
// DDA line rasterizer.
// Input channel (in_valid/in_ready) carries one item: func 0 starts a line
// from (x_start, y_start) to (x_end, y_end), func 1 asks for the next point.
// Output channel (out_valid/out_ready) carries pixel_x, pixel_y and last.
// A start item writes the start pixel into the output register, where it
// shows in the cycle after acceptance. The two increments are then computed
// one after the other by a single shared restoring divider that retires one
// quotient bit per cycle, so the block is not ready until both are done.
// A zero-length line emits its only pixel with last set and skips the
// division. Step items are taken one per cycle unless the output stalls;
// its pixel shows in the cycle after acceptance, or none with no active line.
// The output register holds its item until it is taken. While it is full
// and out_ready is low, in_ready stays low, so a stall on the output side
// holds off the input side. Reset clears the line state and empties the
// output register; the block is ready right after reset.
module dda_line_rasterizer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [dda_pkg::COORD_BITS-1:0] x_start,
    input  logic [dda_pkg::COORD_BITS-1:0] y_start,
    input  logic [dda_pkg::COORD_BITS-1:0] x_end,
    input  logic [dda_pkg::COORD_BITS-1:0] y_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
    output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
    output logic                           last
);
    import dda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIVX = 2'd1;
    localparam logic [1:0] S_DIVY = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  busy_reg, busy_next;
    logic [COORD_BITS-1:0] points_left_reg, points_left_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic                  last_reg, last_next;

    logic [ACC_BITS-1:0]   acc_x_reg, acc_x_next;
    logic [ACC_BITS-1:0]   acc_y_reg, acc_y_next;
    logic [STEP_BITS-1:0]  step_x_reg, step_x_next;
    logic [STEP_BITS-1:0]  step_y_reg, step_y_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    logic [COORD_BITS-1:0] ady_reg, ady_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;

    logic                  accept;
    logic [COORD_BITS:0]   dx, dy, dx_abs, dy_abs;
    logic [COORD_BITS-1:0] adx, ady, steps;
    logic [ACC_BITS-1:0]   acc_x_init, acc_y_init;
    logic [ACC_BITS-1:0]   acc_x_sum, acc_y_sum;
    logic [STEP_BITS-1:0]  quo_ext;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign last      = last_reg;

    assign dx     = {1'b0, x_end} - {1'b0, x_start};
    assign dy     = {1'b0, y_end} - {1'b0, y_start};
    assign dx_abs = dx[COORD_BITS] ? -dx : dx;
    assign dy_abs = dy[COORD_BITS] ? -dy : dy;
    assign adx    = dx_abs[COORD_BITS-1:0];
    assign ady    = dy_abs[COORD_BITS-1:0];
    assign steps  = (adx > ady) ? adx : ady;

    // The half-pixel bias makes truncation of the accumulator round to nearest.
    assign acc_x_init = {x_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign acc_y_init = {y_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign acc_x_sum  = acc_x_reg + {{(ACC_BITS-STEP_BITS){step_x_reg[STEP_BITS-1]}}, step_x_reg};
    assign acc_y_sum  = acc_y_reg + {{(ACC_BITS-STEP_BITS){step_y_reg[STEP_BITS-1]}}, step_y_reg};
    assign quo_ext    = {1'b0, div_rsp.quo};

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = adx;
        div_req.den   = steps;
        if (state_reg == S_DIVX)
        begin
            div_req.start = div_rsp.done;
            div_req.num   = ady_reg;
            div_req.den   = steps_reg;
        end
        else if (accept && func == FUNC_START && steps != '0)
        begin
            div_req.start = 1'b1;
        end
    end

    dda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        points_left_next = points_left_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        last_next        = last_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        ady_next         = ady_reg;
        steps_next       = steps_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && func == FUNC_START)
                begin
                    acc_x_next     = acc_x_init;
                    acc_y_next     = acc_y_init;
                    out_valid_next = 1'b1;
                    pixel_x_next   = x_start;
                    pixel_y_next   = y_start;
                    neg_x_next     = dx[COORD_BITS];
                    neg_y_next     = dy[COORD_BITS];
                    ady_next       = ady;
                    steps_next     = steps;
                    if (steps == '0)
                    begin
                        // A zero-length line is its own last point.
                        step_x_next      = '0;
                        step_y_next      = '0;
                        points_left_next = '0;
                        busy_next        = 1'b0;
                        last_next        = 1'b1;
                    end
                    else
                    begin
                        points_left_next = steps;
                        busy_next        = 1'b1;
                        last_next        = 1'b0;
                        state_next       = S_DIVX;
                    end
                end
                else if (accept && func == FUNC_STEP && busy_reg)
                begin
                    acc_x_next       = acc_x_sum;
                    acc_y_next       = acc_y_sum;
                    points_left_next = points_left_reg - 1'b1;
                    out_valid_next   = 1'b1;
                    pixel_x_next     = acc_x_sum[ACC_BITS-1:FRAC_BITS];
                    pixel_y_next     = acc_y_sum[ACC_BITS-1:FRAC_BITS];
                    last_next        = (points_left_reg == COORD_BITS'(1));
                    busy_next        = (points_left_reg != COORD_BITS'(1));
                end
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    step_x_next = neg_x_reg ? -quo_ext : quo_ext;
                    state_next  = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    step_y_next = neg_y_reg ? -quo_ext : quo_ext;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            busy_reg        <= 1'b0;
            points_left_reg <= '0;
            out_valid_reg   <= 1'b0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            points_left_reg <= points_left_next;
            out_valid_reg   <= out_valid_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        last_reg    <= last_next;
        neg_x_reg   <= neg_x_next;
        neg_y_reg   <= neg_y_next;
        ady_reg     <= ady_next;
        steps_reg   <= steps_next;
    end

endmodule

// ----- rtl/dda_chk.sv -----
module dda_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           func,
    input logic [dda_pkg::COORD_BITS-1:0] x_start,
    input logic [dda_pkg::COORD_BITS-1:0] y_start,
    input logic [dda_pkg::COORD_BITS-1:0] x_end,
    input logic [dda_pkg::COORD_BITS-1:0] y_end,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dda_pkg::COORD_BITS-1:0] pixel_x,
    input logic [dda_pkg::COORD_BITS-1:0] pixel_y,
    input logic                           last
);
    import dda_pkg::*;

    // A stalled output item must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
        && $stable(last))
        else $error("output item changed while stalled");

    // Input is only taken when the output register has room.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("ready while output register is full");

    // Every start item emits its start pixel in the next cycle.
    a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_START |=> out_valid
        && pixel_x == $past(x_start) && pixel_y == $past(y_start))
        else $error("start item did not emit its start pixel");

    // A zero-length line is flagged last at once.
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_START && x_start == x_end
        && y_start == y_end |=> last)
        else $error("zero-length line not flagged last");

endmodule

bind dda_line_rasterizer_top dda_chk u_dda_chk (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dda_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_COORD    = (1 << COORD_BITS) - 1;
    localparam logic [ACC_BITS-1:0] HALF_PIXEL = ACC_BITS'(1) << (FRAC_BITS - 1);

    typedef struct {
        bit                  func;
        bit [COORD_BITS-1:0] x_start;
        bit [COORD_BITS-1:0] y_start;
        bit [COORD_BITS-1:0] x_end;
        bit [COORD_BITS-1:0] y_end;
    } line_cmd_t;

    typedef struct {
        bit [COORD_BITS-1:0] pixel_x;
        bit [COORD_BITS-1:0] pixel_y;
        bit                  last;
    } pixel_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  func      = FUNC_START;
    logic [COORD_BITS-1:0] x_start   = '0;
    logic [COORD_BITS-1:0] y_start   = '0;
    logic [COORD_BITS-1:0] x_end     = '0;
    logic [COORD_BITS-1:0] y_end     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    dda_line_rasterizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

    always #5 clk = ~clk;

    line_cmd_t pending_cmds[$];
    pixel_t    pixel_expected[$];
    int        errors = 0;
    bit        steady = 1'b0;

    // Line state of the predictor.
    logic [ACC_BITS-1:0]         line_acc_x = '0;
    logic [ACC_BITS-1:0]         line_acc_y = '0;
    logic signed [STEP_BITS-1:0] line_inc_x = '0;
    logic signed [STEP_BITS-1:0] line_inc_y = '0;
    int                          line_points_left = 0;
    bit                          line_active = 1'b0;

    // Signed increment: |delta| / span in fixed point, rounded half away from zero.
    function automatic logic signed [STEP_BITS-1:0] dda_increment(longint delta, longint span);
        longint mag;
        longint quo;
        longint rem;
        mag = (delta < 0 ? -delta : delta) << FRAC_BITS;
        quo = mag / span;
        rem = mag % span;
        if (2 * rem >= span)
            quo++;
        return STEP_BITS'(delta < 0 ? -quo : quo);
    endfunction

    task automatic rasterize_item(input line_cmd_t cmd);
        longint dx;
        longint dy;
        longint span;
        pixel_t pix;
        if (cmd.func == FUNC_START) begin
            dx = longint'(cmd.x_end) - longint'(cmd.x_start);
            dy = longint'(cmd.y_end) - longint'(cmd.y_start);
            span = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > span)
                span = (dy < 0 ? -dy : dy);
            line_acc_x = {cmd.x_start, {FRAC_BITS{1'b0}}} + HALF_PIXEL;
            line_acc_y = {cmd.y_start, {FRAC_BITS{1'b0}}} + HALF_PIXEL;
            if (span == 0) begin
                line_inc_x = '0;
                line_inc_y = '0;
                line_points_left = 0;
                line_active = 1'b0;
                pix.last = 1'b1;
            end else begin
                line_inc_x = dda_increment(dx, span);
                line_inc_y = dda_increment(dy, span);
                line_points_left = int'(span);
                line_active = 1'b1;
                pix.last = 1'b0;
            end
        end else begin
            if (!line_active)
                return;
            line_acc_x = line_acc_x + ACC_BITS'(line_inc_x);
            line_acc_y = line_acc_y + ACC_BITS'(line_inc_y);
            line_points_left--;
            line_active = (line_points_left != 0);
            pix.last = !line_active;
        end
        pix.pixel_x = line_acc_x[ACC_BITS-1:FRAC_BITS];
        pix.pixel_y = line_acc_y[ACC_BITS-1:FRAC_BITS];
        pixel_expected.push_back(pix);
    endtask

    task automatic queue_start(input int xs, input int ys, input int xe, input int ye);
        line_cmd_t cmd;
        cmd.func    = FUNC_START;
        cmd.x_start = COORD_BITS'(xs);
        cmd.y_start = COORD_BITS'(ys);
        cmd.x_end   = COORD_BITS'(xe);
        cmd.y_end   = COORD_BITS'(ye);
        pending_cmds.push_back(cmd);
    endtask

    // Step items carry random coordinates, which the block must ignore.
    task automatic queue_steps(input int count);
        line_cmd_t cmd;
        for (int i = 0; i < count; i++) begin
            cmd.func    = FUNC_STEP;
            cmd.x_start = COORD_BITS'($urandom);
            cmd.y_start = COORD_BITS'($urandom);
            cmd.x_end   = COORD_BITS'($urandom);
            cmd.y_end   = COORD_BITS'($urandom);
            pending_cmds.push_back(cmd);
        end
    endtask

    // Offset a coordinate by a signed amount, flipping direction at the edges.
    function automatic int offset_coord(int base, int delta);
        int c;
        c = base + delta;
        if (c < 0 || c > MAX_COORD)
            c = base - delta;
        return c;
    endfunction

    // Queue a start item for a line of the given span with random slope and
    // direction; returns nothing, the caller queues the steps.
    task automatic queue_random_line(input int span);
        int xs;
        int ys;
        int dx;
        int dy;
        xs = $urandom_range(0, MAX_COORD);
        ys = $urandom_range(0, MAX_COORD);
        if ($urandom_range(0, 1) == 0) begin
            dx = span;
            dy = $urandom_range(0, span);
        end else begin
            dx = $urandom_range(0, span);
            dy = span;
        end
        if ($urandom_range(0, 1) == 1)
            dx = -dx;
        if ($urandom_range(0, 1) == 1)
            dy = -dy;
        queue_start(xs, ys, offset_coord(xs, dx), offset_coord(ys, dy));
    endtask

    // Toggles between stretches of random idling and stretches of none.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            steady <= ~steady;
    end

    line_cmd_t shown_cmd;
    int        in_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit took;
        int gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_hold  <= 0;
        end else begin
            took = in_valid && in_ready;
            gap = 0;
            if (took) begin
                rasterize_item(shown_cmd);
                gap = steady ? 0 : $urandom_range(0, 3);
            end
            if (took || !in_valid) begin
                if (((took && gap == 0) || (!took && in_hold == 0)) &&
                    pending_cmds.size() != 0) begin
                    shown_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    func     <= shown_cmd.func;
                    x_start  <= shown_cmd.x_start;
                    y_start  <= shown_cmd.y_start;
                    x_end    <= shown_cmd.x_end;
                    y_end    <= shown_cmd.y_end;
                    in_hold  <= 0;
                end else begin
                    in_valid <= 1'b0;
                    if (took && gap > 0)
                        in_hold <= gap - 1;
                    else if (!took && in_hold > 0)
                        in_hold <= in_hold - 1;
                end
            end
        end
    end

    int out_hold = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        int     stall;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end else if (out_valid && out_ready) begin
            if (pixel_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected pixel: x=%0d y=%0d last=%0b",
                             pixel_x, pixel_y, last);
            end else begin
                want = pixel_expected.pop_front();
                if (pixel_x !== want.pixel_x || pixel_y !== want.pixel_y ||
                    last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 want.pixel_x, want.pixel_y, want.last,
                                 pixel_x, pixel_y, last);
                end
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                out_hold  <= stall - 1;
            end
        end else if (!out_ready) begin
            if (out_hold == 0)
                out_ready <= 1'b1;
            else
                out_hold <= out_hold - 1;
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("FAIL dda_line_rasterizer_top");
            $finish;
        end
    end

    initial
    begin
        int count;
        int kind;
        int span;
        int xs;
        int ys;

        // Directed part: idle steps, zero-length lines at the corners,
        // full-range diagonals interrupted by new starts, and short lines
        // walked to the end, the first with a trailing idle step.
        queue_steps(1);
        queue_start(0, 0, 0, 0);
        queue_start(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
        queue_steps(1);
        queue_start(0, 0, MAX_COORD, MAX_COORD);
        queue_steps(2);
        queue_start(MAX_COORD, 0, 0, MAX_COORD);
        queue_steps(2);
        queue_start(MAX_COORD, MAX_COORD, 0, 0);
        queue_steps(1);
        queue_start(0, MAX_COORD, MAX_COORD, 0);
        queue_steps(1);
        queue_start(100, 200, 103, 201);
        queue_steps(4);
        queue_start(50, 50, 49, 53);
        queue_steps(3);

        // Random part: mostly complete lines, some cut short by a new start,
        // and some noise made of arbitrary endpoints and idle steps.
        count = 0;
        while (count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 300)
                                                : $urandom_range(0, 12);
            if (kind < 8) begin
                queue_random_line(span);
                queue_steps(span);
                count += 1 + span;
                if ($urandom_range(0, 4) == 0)
                    queue_steps($urandom_range(1, 2));
            end else if (kind == 8) begin
                if (span == 0)
                    span = 1;
                queue_random_line(span);
                span = $urandom_range(0, span - 1);
                queue_steps(span);
                count += 1 + span;
            end else begin
                xs = $urandom_range(0, MAX_COORD);
                ys = $urandom_range(0, MAX_COORD);
                queue_start(xs, ys, $urandom_range(0, MAX_COORD),
                            $urandom_range(0, MAX_COORD));
                span = $urandom_range(0, 3);
                queue_steps(span);
                count += 1 + span;
            end
        end

        repeat (4) @(posedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || in_valid || pixel_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pixel_expected.size() != 0)
            $display("%0d expected pixels never arrived", pixel_expected.size());
        if (errors == 0 && pixel_expected.size() == 0)
            $display("PASS dda_line_rasterizer_top");
        else
            $display("FAIL dda_line_rasterizer_top");
        $finish;
    end

endmodule
